### hw/rtl/arpc_pkg.sv
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int STAMP_W = 32;
	localparam int TTL_W = 8;
	localparam int SLOT_W = 4;
	localparam int ENTRY_W = STAMP_W + MAC_W + IP_W;

	localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(5);

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_STALE    = 2'd1,
		ST_MISS     = 2'd2,
		ST_INSERTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [MAC_W-1:0]   mac;
		logic [IP_W-1:0]    ip;
	} entry_t;

endpackage

### hw/rtl/arp_cache_with_aging.sv
// IPv4-to-MAC cache of ENTRIES slots with time-to-live aging. Input items carry the
// kind in in_tuser: a tick advances the seconds counter and gives no result, kind 3
// is dropped, a lookup or an insert gives one result item. Entries sit in one
// single-port-read RAM and are walked one per cycle through its read port; a lookup
// stops at the first matching slot, while a miss or an insert walks all ENTRIES slots.
// One item is worked on at a time, and the next is taken while a finished result
// still waits in the output register. Valid bits are flip-flops cleared at reset, so
// no clearing pass is needed.
module arp_cache_with_aging
	import arpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TTL_W-1:0]  cfg_wdata,
	input  logic              in_tvalid,
	output logic              in_tready,
	input  logic [79:0]       in_tdata,   // ip_address, mac_in
	input  logic [1:0]        in_tuser,   // kind
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [55:0]       out_tdata,  // mac_out, slot
	output logic [1:0]        out_tuser   // status
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_POST = 3'b100
	} state_t;

	state_t                state_q;
	logic [TTL_W-1:0]      ttl_q;
	logic [STAMP_W-1:0]    seconds_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  issue_q;
	logic                  chk_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  ins_q;
	logic [IP_W-1:0]       ip_q;
	logic [MAC_W-1:0]      mac_q;
	logic                  inv_found_q;
	logic [IDX_W-1:0]      inv_idx_q;
	logic [STAMP_W-1:0]    best_age_q;
	logic [IDX_W-1:0]      best_idx_q;
	status_t               pend_status_q;
	logic [MAC_W-1:0]      pend_mac_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [MAC_W-1:0]      out_mac_q;
	logic [SLOT_W-1:0]     out_slot_q;

	logic                  in_acc;
	kind_t                 in_kind;
	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  ram_we;
	logic [STAMP_W-1:0]    age;
	logic                  cur_valid;
	logic                  match;
	logic                  last_s1;
	logic                  inv_found_n;
	logic [IDX_W-1:0]      inv_idx_n;
	logic [STAMP_W-1:0]    best_age_n;
	logic [IDX_W-1:0]      best_idx_n;
	logic [IDX_W-1:0]      victim;
	logic                  finish;
	logic                  out_free;

	assign in_tready = (state_q == S_IDLE);
	assign in_acc = in_tvalid && in_tready;
	assign in_kind = kind_t'(in_tuser);
	assign out_free = !out_valid_q || out_tready;

	arpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (victim),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	always_comb begin
		cur_valid = valid_q[idx_s1];
		age = seconds_q - rd_entry.stamp;
		match = cur_valid && (rd_entry.ip == ip_q);
		last_s1 = (idx_s1 == LAST_IDX);
		inv_found_n = inv_found_q;
		inv_idx_n = inv_idx_q;
		best_age_n = best_age_q;
		best_idx_n = best_idx_q;
		if (!cur_valid && !inv_found_q) begin
			inv_found_n = 1'b1;
			inv_idx_n = idx_s1;
		end
		if (cur_valid && (age > best_age_q)) begin
			best_age_n = age;
			best_idx_n = idx_s1;
		end
		victim = inv_found_n ? inv_idx_n : best_idx_n;
		finish = (state_q == S_WALK) && chk_s1 && (ins_q ? last_s1 : (match || last_s1));
		ram_we = finish && ins_q;
		wr_entry.stamp = seconds_q;
		wr_entry.mac = mac_q;
		wr_entry.ip = ip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ttl_q <= TTL_RESET;
			seconds_q <= '0;
			valid_q <= '0;
			issue_q <= 1'b0;
			chk_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
			if ((state_q == S_POST) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
			chk_s1 <= (state_q == S_WALK) && issue_q;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_kind)
							KIND_LOOKUP, KIND_INSERT: begin
								state_q <= S_WALK;
								issue_q <= 1'b1;
							end
							KIND_TICK: begin
								seconds_q <= seconds_q + STAMP_W'(1);
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (finish || (issue_q && (idx_q == LAST_IDX))) begin
						issue_q <= 1'b0;
					end
					if (finish) begin
						state_q <= S_POST;
						if (ins_q) begin
							valid_q[victim] <= 1'b1;
						end else if (match && (age > STAMP_W'(ttl_q))) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
				end
				S_POST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ip_q <= in_tdata[IP_W-1:0];
			mac_q <= in_tdata[IP_W+MAC_W-1:IP_W];
			ins_q <= (in_kind == KIND_INSERT);
			idx_q <= '0;
			inv_found_q <= 1'b0;
			inv_idx_q <= '0;
			best_age_q <= '0;
			best_idx_q <= '0;
		end else if (state_q == S_WALK) begin
			if (issue_q) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (chk_s1) begin
				inv_found_q <= inv_found_n;
				inv_idx_q <= inv_idx_n;
				best_age_q <= best_age_n;
				best_idx_q <= best_idx_n;
			end
		end
		idx_s1 <= idx_q;
		if (finish) begin
			if (ins_q) begin
				pend_status_q <= ST_INSERTED;
				pend_mac_q <= '0;
				pend_idx_q <= victim;
			end else if (match) begin
				pend_status_q <= (age > STAMP_W'(ttl_q)) ? ST_STALE : ST_HIT;
				pend_mac_q <= rd_entry.mac;
				pend_idx_q <= idx_s1;
			end else begin
				pend_status_q <= ST_MISS;
				pend_mac_q <= '0;
				pend_idx_q <= '0;
			end
		end
		if ((state_q == S_POST) && out_free) begin
			out_status_q <= pend_status_q;
			out_mac_q <= pend_mac_q;
			out_slot_q <= SLOT_W'(pend_idx_q);
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tuser = out_status_q;
	assign out_tdata = {4'd0, out_slot_q, out_mac_q};

	a_ram_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_WALK) && chk_s1 && ins_q)
		else $error("entry written outside an insert walk");

	a_stale_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && pend_status_q == ST_STALE) |-> !valid_q[pend_idx_q])
		else $error("stale entry still valid");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && pend_status_q == ST_INSERTED) |-> valid_q[pend_idx_q])
		else $error("inserted entry not valid");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_MISS || out_status_q == ST_INSERTED))
		|-> (out_mac_q == '0))
		else $error("nonzero mac on miss or insert");

	a_seconds_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(seconds_q != $past(seconds_q)) |-> $past(in_acc && in_kind == KIND_TICK))
		else $error("seconds counter moved without a tick");

endmodule

### hw/rtl/arpc_ram.sv
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
